/* rtl/core/bdgm_pkg.sv */
package bdgm_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int THR_W     = 10;
	localparam int LVL_W     = 8;
	localparam int MEAN_W    = 16;
	localparam int BINS      = 256;
	// horizontal bins in the lower half, vertical bins in the upper half
	localparam int SEEN_AW   = $clog2(2 * BINS);

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [LVL_W-1:0]     lvl_t;

	localparam cfg_idx_t REG_FRAME_WIDTH     = 2'd0;
	localparam cfg_idx_t REG_FRAME_HEIGHT    = 2'd1;
	localparam cfg_idx_t REG_SHARP_THRESHOLD = 2'd2;

	localparam cfg_data_t        RST_FRAME_WIDTH  = 13'd640;
	localparam cfg_data_t        RST_FRAME_HEIGHT = 13'd480;
	localparam logic [THR_W-1:0] RST_THRESHOLD    = 10'd700;

	// threshold is scaled by 2*256 (levels) times 256 (q8.8 sum)
	localparam int THR_SHIFT = 17;
	localparam int SQRT_W    = 32;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_RD_UP  = 10'b00_0000_0010,
		S_RD_RT  = 10'b00_0000_0100,
		S_MARK_V = 10'b00_0000_1000,
		S_SQRT   = 10'b00_0001_0000,
		S_FIN    = 10'b00_0010_0000,
		S_MUL    = 10'b00_0100_0000,
		S_DIV    = 10'b00_1000_0000,
		S_DONE   = 10'b01_0000_0000,
		S_CLR    = 10'b10_0000_0000
	} state_t;

	function automatic pix_t abs_diff(input pix_t a, input pix_t b);
		return (a > b) ? pix_t'(a - b) : pix_t'(b - a);
	endfunction

endpackage

/* rtl/core/bdgm_ram.sv */
module bdgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/blur_detect_gradient_metric_core.sv */
// one pixel at a time: in_ready returns after the row fetch, bin marking and, when a gradient
// term is added, the 16-step bit-serial square root unit
// frame end adds the size product, a 10-step shift-add compare, a 40-step divider and the
// output load, waits while the previous result is held, then clears all 512 bins
// async reset sets config to 640 x 480 / 700, clears position and sum, sets level counts to 1;
// the bins are cleared by the same clear pass before the first transfer, the line buffer is not
module blur_detect_gradient_metric_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  bdgm_pkg::cfg_idx_t       cfg_index,
	input  bdgm_pkg::cfg_data_t      cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  bdgm_pkg::pix_t           pixel,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     sharp,
	output logic [15:0]              mean_gradient,
	output bdgm_pkg::lvl_t           levels_horizontal,
	output bdgm_pkg::lvl_t           levels_vertical
);

	import bdgm_pkg::*;

	localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HHW   = $clog2(MAX_HEIGHT + 1);
	localparam int EW0   = (WW > HHW) ? WW : HHW;
	localparam int EW    = (EW0 > CFG_W) ? EW0 + 1 : CFG_W + 1;
	localparam int NW    = CW + HW;
	localparam int SUM_W = 16 + NW;
	localparam int PA_W  = SUM_W + LVL_W + 1;
	localparam int PB_W  = THR_W + THR_SHIFT + NW;
	localparam int PW    = (PA_W > PB_W) ? PA_W : PB_W;
	localparam int STW   = $clog2(SUM_W);

	state_t state_q;

	cfg_data_t        frame_width_q, frame_height_q;
	logic [THR_W-1:0] threshold_q;

	logic [CW-1:0]   col_q;
	logic [HW-1:0]   row_q;
	pix_t            px_q, up_q, left_q;
	logic            last_q, grad_q, chk_v_q;
	lvl_t            cnt_h_q, cnt_v_q;
	logic [SUM_W-1:0] sum_q;
	logic [SEEN_AW-1:0] clr_q;

	logic [SQRT_W-1:0] v_q, res_q, bit_q;

	logic [NW-1:0]    num_q;
	logic [PW-1:0]    mcand_a_q, mcand_b_q, prod_a_q, prod_b_q;
	logic [THR_W-1:0] lv_q, thr_sh_q;
	logic [STW-1:0]   step_q;
	logic [NW-1:0]    rem_q;
	logic [SUM_W-1:0] dq_q;

	logic              out_valid_q, sharp_q;
	logic [MEAN_W-1:0] mean_q;
	lvl_t              lev_h_q, lev_v_q;

	logic [EW-1:0] w_ext, h_ext;
	logic [CW-1:0] w_m1;
	logic [HW-1:0] h_m1;
	logic          c_last, r_last;

	logic [CW-1:0] raddr;
	pix_t          rdata;
	logic          ram_we;

	logic [SEEN_AW-1:0] seen_raddr, seen_waddr;
	logic               seen_we, seen_wdata, seen_rd;
	logic               mark_h, mark_v;

	pix_t        dh, dv, dx;
	logic [16:0] sq_sum;

	logic [SQRT_W-1:0] trial, nres, nv;
	logic              ge;

	logic [NW:0] div_t;
	logic        div_ge;
	logic        out_free;

	always_comb begin
		if (frame_width_q < CFG_W'(2)) w_ext = EW'(2);
		else if (EW'(frame_width_q) > EW'(MAX_WIDTH)) w_ext = EW'(MAX_WIDTH);
		else w_ext = EW'(frame_width_q);
		if (frame_height_q < CFG_W'(2)) h_ext = EW'(2);
		else if (EW'(frame_height_q) > EW'(MAX_HEIGHT)) h_ext = EW'(MAX_HEIGHT);
		else h_ext = EW'(frame_height_q);
	end

	assign w_m1   = CW'(w_ext - EW'(1));
	assign h_m1   = HW'(h_ext - EW'(1));
	assign c_last = (EW'(col_q) + EW'(1)) >= w_ext;
	assign r_last = (EW'(row_q) + EW'(1)) >= h_ext;

	assign raddr  = (state_q == S_RD_UP) ? CW'(col_q + CW'(1)) : col_q;
	assign ram_we = (state_q == S_RD_RT);

	bdgm_ram #(
		.WIDTH(PIX_W),
		.DEPTH(2 ** CW)
	) u_row_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_q),
		.wdata(px_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign dh     = abs_diff(px_q, left_q);
	assign dv     = abs_diff(px_q, up_q);
	assign dx     = abs_diff(rdata, up_q);
	assign sq_sum = 17'(16'(dx) * 16'(dx)) + 17'(16'(dv) * 16'(dv));

	// horizontal bin read while the row above is fetched, vertical bin in the cycle after
	// bin zero is counted from the start and 255 never counts
	assign seen_raddr = (state_q == S_RD_UP) ? {1'b0, dh} : {1'b1, dv};
	assign mark_h     = (col_q != '0) && (dh != '0) && (dh != 8'hFF) && !seen_rd;
	assign mark_v     = chk_v_q && !seen_rd;
	assign seen_we    = (state_q == S_CLR) || ((state_q == S_RD_RT) && mark_h) ||
	                    ((state_q == S_MARK_V) && mark_v);
	assign seen_waddr = (state_q == S_CLR) ? clr_q :
	                    (state_q == S_RD_RT) ? {1'b0, dh} : {1'b1, dv};
	assign seen_wdata = (state_q != S_CLR);

	bdgm_ram #(
		.WIDTH(1),
		.DEPTH(2 * BINS)
	) u_seen_bins (
		.clk  (clk),
		.we   (seen_we),
		.waddr(seen_waddr),
		.wdata(seen_wdata),
		.raddr(seen_raddr),
		.rdata(seen_rd)
	);

	// one result bit per step
	assign trial = res_q + bit_q;
	assign ge    = v_q >= trial;
	assign nv    = ge ? v_q - trial : v_q;
	assign nres  = ge ? (res_q >> 1) + bit_q : res_q >> 1;

	assign div_t  = {rem_q, dq_q[SUM_W-1]};
	assign div_ge = div_t >= (NW+1)'(num_q);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			threshold_q    <= RST_THRESHOLD;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:     frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT:    frame_height_q <= cfg_data;
				REG_SHARP_THRESHOLD: threshold_q    <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= '0;
			last_q      <= 1'b0;
			grad_q      <= 1'b0;
			chk_v_q     <= 1'b0;
			cnt_h_q     <= LVL_W'(1);
			cnt_v_q     <= LVL_W'(1);
			sum_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						px_q    <= pixel;
						state_q <= S_RD_UP;
					end
				end
				S_RD_UP: begin
					up_q    <= rdata;
					state_q <= S_RD_RT;
				end
				S_RD_RT: begin
					if (mark_h) begin
						cnt_h_q <= cnt_h_q + LVL_W'(1);
					end
					chk_v_q <= (row_q != '0) && (dv != '0) && (dv != 8'hFF);
					grad_q  <= (row_q != '0) && !c_last;
					left_q  <= px_q;
					v_q     <= {sq_sum[16:1], 16'h0000};
					res_q   <= '0;
					bit_q   <= SQRT_W'(1) << (SQRT_W - 2);
					last_q  <= c_last && r_last;
					if (c_last) begin
						col_q <= '0;
						row_q <= r_last ? '0 : HW'(row_q + HW'(1));
					end else begin
						col_q <= CW'(col_q + CW'(1));
					end
					state_q <= S_MARK_V;
				end
				S_MARK_V: begin
					if (mark_v) begin
						cnt_v_q <= cnt_v_q + LVL_W'(1);
					end
					if (grad_q) state_q <= S_SQRT;
					else if (last_q) state_q <= S_FIN;
					else state_q <= S_IDLE;
				end
				S_SQRT: begin
					v_q   <= nv;
					res_q <= nres;
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						sum_q   <= sum_q + SUM_W'(nres);
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					num_q     <= NW'(w_m1) * NW'(h_m1);
					mcand_a_q <= PW'(sum_q);
					mcand_b_q <= PW'(NW'(w_m1) * NW'(h_m1)) << THR_SHIFT;
					lv_q      <= THR_W'(cnt_h_q) + THR_W'(cnt_v_q);
					thr_sh_q  <= threshold_q;
					prod_a_q  <= '0;
					prod_b_q  <= '0;
					step_q    <= '0;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					if (lv_q[0]) prod_a_q <= prod_a_q + mcand_a_q;
					if (thr_sh_q[0]) prod_b_q <= prod_b_q + mcand_b_q;
					mcand_a_q <= mcand_a_q << 1;
					mcand_b_q <= mcand_b_q << 1;
					lv_q      <= lv_q >> 1;
					thr_sh_q  <= thr_sh_q >> 1;
					if (step_q == STW'(THR_W - 1)) begin
						rem_q   <= '0;
						dq_q    <= sum_q;
						step_q  <= '0;
						state_q <= S_DIV;
					end else begin
						step_q <= step_q + STW'(1);
					end
				end
				S_DIV: begin
					rem_q  <= div_ge ? NW'(div_t - (NW+1)'(num_q)) : NW'(div_t);
					dq_q   <= {dq_q[SUM_W-2:0], div_ge};
					step_q <= step_q + STW'(1);
					if (step_q == STW'(SUM_W - 1)) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						sharp_q     <= prod_a_q > prod_b_q;
						mean_q      <= (|dq_q[SUM_W-1:MEAN_W]) ? '1 : dq_q[MEAN_W-1:0];
						lev_h_q     <= cnt_h_q;
						lev_v_q     <= cnt_v_q;
						cnt_h_q     <= LVL_W'(1);
						cnt_v_q     <= LVL_W'(1);
						sum_q       <= '0;
						left_q      <= '0;
						state_q     <= S_CLR;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + SEEN_AW'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign sharp             = sharp_q;
	assign mean_gradient     = mean_q;
	assign levels_horizontal = lev_h_q;
	assign levels_vertical   = lev_v_q;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import bdgm_pkg::*;

	localparam int MAX_W = 4096;
	localparam int MAX_H = 4096;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct packed {
		logic        sharp;
		logic [15:0] mean;
		lvl_t        lvl_h;
		lvl_t        lvl_v;
	} frame_result_t;

	typedef struct {
		bit            do_cfg;
		int            width;
		int            height;
		int            thresh;
		pix_t          pix;
		bit            typed;
		frame_result_t res;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_write = 1'b0;
	cfg_idx_t  cfg_index = REG_FRAME_WIDTH;
	cfg_data_t cfg_data = '0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	pix_t      pixel = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	logic        sharp;
	logic [15:0] mean_gradient;
	lvl_t        levels_horizontal;
	lvl_t        levels_vertical;

	blur_detect_gradient_metric_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
		.out_valid(out_valid), .out_ready(out_ready),
		.sharp(sharp), .mean_gradient(mean_gradient),
		.levels_horizontal(levels_horizontal), .levels_vertical(levels_vertical)
	);

	// predictor state
	logic [12:0] m_width = 13'd640;
	logic [12:0] m_height = 13'd480;
	logic [9:0]  m_thresh = 10'd700;
	pix_t        m_line [MAX_W];
	pix_t        m_left;
	int          m_col, m_row;
	bit          m_seen_h [256];
	bit          m_seen_v [256];
	int          m_cnt_h, m_cnt_v;
	logic [63:0] m_sum;

	frame_result_t frames_expected[$];
	int  errors = 0;
	int  pixels_sent = 0;
	int  frames_checked = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	longint cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int clamp_size(logic [12:0] v, int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return int'(v);
	endfunction

	function automatic int pix_dist(pix_t a, pix_t b);
		return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
	endfunction

	function automatic logic [15:0] root_q88(logic [31:0] v);
		logic [15:0] r;
		logic [15:0] t;
		r = '0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (16'd1 << b);
			if (64'(t) * 64'(t) <= 64'(v))
				r = t;
		end
		return r;
	endfunction

	task automatic restart_frame();
		m_col = 0;
		m_row = 0;
		m_left = '0;
		for (int i = 0; i < 256; i++) begin
			m_seen_h[i] = 0;
			m_seen_v[i] = 0;
		end
		m_seen_h[0] = 1;
		m_seen_v[0] = 1;
		m_cnt_h = 1;
		m_cnt_v = 1;
		m_sum = '0;
	endtask

	// advances the gradient model by one pixel; got is set at frame end
	task automatic gradient_step(input pix_t p, output bit got, output frame_result_t res);
		int w, h, c, r, d, dx, dy, n;
		pix_t up;
		logic [63:0] num, mean;
		w = clamp_size(m_width, MAX_W);
		h = clamp_size(m_height, MAX_H);
		c = (m_col >= MAX_W) ? MAX_W - 1 : m_col;
		r = m_row;
		got = 0;
		res = '0;
		if (c > 0) begin
			d = pix_dist(p, m_left);
			if (d < 255 && !m_seen_h[d]) begin
				m_seen_h[d] = 1;
				m_cnt_h++;
			end
		end
		if (r > 0) begin
			up = m_line[c];
			d = pix_dist(p, up);
			if (d < 255 && !m_seen_v[d]) begin
				m_seen_v[d] = 1;
				m_cnt_v++;
			end
			if (c + 1 < w) begin
				dx = pix_dist(m_line[c + 1], up);
				dy = d;
				n = (dx * dx + dy * dy) >> 1;
				m_sum += 64'(root_q88(32'(n) << 16));
			end
		end
		m_line[c] = p;
		m_left = p;
		if (c + 1 >= w) begin
			m_col = 0;
			if (r + 1 >= h) begin
				num = 64'(h - 1) * 64'(w - 1);
				mean = m_sum / num;
				res.sharp = (64'(m_cnt_h + m_cnt_v) * m_sum) >
					(64'(m_thresh) * 64'd131072 * num);
				res.mean = (mean > 64'hFFFF) ? 16'hFFFF : mean[15:0];
				res.lvl_h = lvl_t'(m_cnt_h);
				res.lvl_v = lvl_t'(m_cnt_v);
				got = 1;
				restart_frame();
			end else begin
				m_row = r + 1;
			end
		end else begin
			m_col = c + 1;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch frame %0d %s: got %0d want %0d", frames_checked, what, got, want);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frames_expected.size() == 0) begin
				report_mismatch("unexpected result transfer", 1, 0);
			end else begin
				want = frames_expected.pop_front();
				if (sharp !== want.sharp)
					report_mismatch("sharp", sharp, want.sharp);
				if (mean_gradient !== want.mean)
					report_mismatch("mean_gradient", mean_gradient, want.mean);
				if (levels_horizontal !== want.lvl_h)
					report_mismatch("levels_horizontal", levels_horizontal, want.lvl_h);
				if (levels_vertical !== want.lvl_v)
					report_mismatch("levels_vertical", levels_vertical, want.lvl_v);
				frames_checked++;
			end
		end
	end

	task automatic send_pixel(input pix_t p, input bit typed, input frame_result_t typed_res);
		int gap;
		bit got;
		frame_result_t res;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		gradient_step(p, got, res);
		if (got)
			frames_expected.push_back(typed ? typed_res : res);
	endtask

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_pixel(pix_t'($urandom_range(255)), 0, '0);
	endtask

	// sender holds off until every frame result is back and the block is idle again
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (frames_expected.size() != 0 || !in_ready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input int val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= cfg_data_t'(val);
		@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:     m_width = 13'(val);
			REG_FRAME_HEIGHT:    m_height = 13'(val);
			REG_SHARP_THRESHOLD: m_thresh = 10'(val);
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int w, input int h, input int thr);
		drain();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_SHARP_THRESHOLD, thr);
		cfg_write <= 1'b0;
	endtask

	task automatic random_frame();
		int w, h, style, base;
		pix_t p;
		w = clamp_size(m_width, MAX_W);
		h = clamp_size(m_height, MAX_H);
		style = $urandom_range(3);
		base = $urandom_range(255);
		for (int i = 0; i < w * h; i++) begin
			case (style)
				0: p = pix_t'($urandom_range(255));
				1: begin
					base = base + $urandom_range(6) - 3;
					if (base < 0) base = 0;
					if (base > 255) base = 255;
					p = pix_t'(base);
				end
				2: p = $urandom_range(1) ? 8'd255 : 8'd0;
				default: p = $urandom_range(3) == 0 ? pix_t'($urandom_range(255))
					: pix_t'((base + $urandom_range(40)) & 8'hFF);
			endcase
			send_pixel(p, 0, '0);
		end
	endtask

	task automatic random_phase(input int quota);
		int start;
		start = pixels_sent;
		while (pixels_sent - start < quota) begin
			if ($urandom_range(99) < 35)
				set_geometry($urandom_range(2, 9), $urandom_range(2, 7),
					$urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(12));
			random_frame();
		end
	endtask

	stim_row_t directed [] = '{
		'{1, 2, 2, 0, 8'd0, 0, '0},
		'{0, 0, 0, 0, 8'd0, 0, '0},
		'{0, 0, 0, 0, 8'd0, 0, '0},
		'{0, 0, 0, 0, 8'd0, 0, '0},
		// flat frame: only bin zero counts, no gradient
		'{0, 0, 0, 0, 8'd0, 1, '{1'b0, 16'd0, 8'd1, 8'd1}},
		'{0, 0, 0, 0, 8'd0, 0, '0},
		'{0, 0, 0, 0, 8'd255, 0, '0},
		'{0, 0, 0, 0, 8'd255, 0, '0},
		// all differences are 255: never counted, full-scale gradient
		'{0, 0, 0, 0, 8'd0, 1, '{1'b1, 16'd65280, 8'd1, 8'd1}},
		'{1, 3, 2, 1023, 8'd0, 0, '0},
		'{0, 0, 0, 0, 8'd255, 0, '0},
		'{0, 0, 0, 0, 8'd254, 0, '0},
		'{0, 0, 0, 0, 8'd1, 0, '0},
		'{0, 0, 0, 0, 8'd0, 0, '0},
		'{0, 0, 0, 0, 8'd128, 0, '0},
		'{0, 0, 0, 0, 8'd7, 0, '0},
		// out-of-range sizes clamp to 2 x 2
		'{1, 0, 1, 512, 8'd10, 0, '0},
		'{0, 0, 0, 0, 8'd20, 0, '0},
		'{0, 0, 0, 0, 8'd30, 0, '0},
		'{0, 0, 0, 0, 8'd40, 0, '0}
	};

	initial begin
		restart_frame();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].do_cfg)
				set_geometry(directed[i].width, directed[i].height, directed[i].thresh);
			else
				send_pixel(directed[i].pix, directed[i].typed, directed[i].res);
		end

		send_idle_pct = 31;
		recv_idle_pct = 84;
		random_phase(530);
		send_idle_pct = 84;
		recv_idle_pct = 31;
		random_phase(530);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(540);

		// sizes above range clamp to the maximum; shrinking the size mid-frame
		// ends the row or the frame on the current pixel
		set_geometry(8191, 2, 0);
		send_random(20);
		set_geometry(21, 2, 1023);
		send_random(22);
		set_geometry(2, 8191, 3);
		send_random(12);
		set_geometry(2, 7, 3);
		send_random(2);

		drain();
		$display("checked %0d frame results from %0d pixels", frames_checked, pixels_sent);
		$display("frames from 2x2 to 9x7, clamped sizes, mid-frame resizing, thresholds 0 to 1023");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/bdgm_pkg.sv
rtl/core/bdgm_ram.sv
rtl/core/blur_detect_gradient_metric_core.sv
bench/tb_top.sv
